// File: hdl/fcdd_pkg.sv
// ----------------------------------------------------------------------------
// Fingertip cell dwell detector: shared types and constants
// Frame geometry, grid cell coding and the entry format kept in the windows.
// ----------------------------------------------------------------------------
package fcdd_pkg;

    // Frame and grid geometry
    localparam int CELL_SIZE    = 16;
    localparam int CELL_SHIFT   = $clog2(CELL_SIZE);
    localparam int FRAME_WIDTH  = 640;
    localparam int FRAME_HEIGHT = 320;
    localparam int GRID_COLS    = FRAME_WIDTH / CELL_SIZE;

    // Field widths
    localparam int X_W    = 10;
    localparam int Y_W    = 9;
    localparam int CODE_W = 10;
    localparam int COL_W  = 6;
    localparam int ROW_W  = 5;

    // Offset from a cell corner to its centre
    localparam logic [CELL_SHIFT-1:0] HALF_CELL = CELL_SHIFT'(CELL_SIZE / 2);

    // One window entry: the cell code and its column and row, normalised so
    // that col = code mod GRID_COLS and row = code div GRID_COLS
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
    } t_cell_entry;

endpackage

// File: hdl/fcdd_cell_map.sv
// ----------------------------------------------------------------------------
// Fingertip cell dwell detector: point to grid cell mapping
// Clamps a point to the frame and gives its cell code, column and row.
// ----------------------------------------------------------------------------
module fcdd_cell_map
    import fcdd_pkg::*;
(
    input  logic [X_W-1:0] i_point_x,
    input  logic [Y_W-1:0] i_point_y,
    output t_cell_entry    o_entry
);

    logic [X_W-1:0]    x_sat;
    logic [Y_W-1:0]    y_sat;
    logic [COL_W-1:0]  col_raw;
    logic [ROW_W-1:0]  row_raw;
    logic [CODE_W-1:0] code;

    // Clamp to the frame edge
    assign x_sat = (i_point_x > X_W'(FRAME_WIDTH))  ? X_W'(FRAME_WIDTH)  : i_point_x;
    assign y_sat = (i_point_y > Y_W'(FRAME_HEIGHT)) ? Y_W'(FRAME_HEIGHT) : i_point_y;

    assign col_raw = COL_W'(x_sat >> CELL_SHIFT);
    assign row_raw = ROW_W'(y_sat >> CELL_SHIFT);
    assign code    = CODE_W'(col_raw) + CODE_W'(GRID_COLS) * CODE_W'(row_raw);

    // Right frame edge lands on column GRID_COLS: fold it into the next row
    always_comb begin
        o_entry.code = code;
        if (col_raw == COL_W'(GRID_COLS)) begin
            o_entry.col = '0;
            o_entry.row = row_raw + ROW_W'(1);
        end else begin
            o_entry.col = col_raw;
            o_entry.row = row_raw;
        end
    end

endmodule

// File: hdl/fingertip_cell_dwell_detector_unit.sv
// Each input transaction is mapped to its cell and pushed into the window, which is then
// scanned for the most frequent cell; the vote scan stops once no later entry can win, and
// the result is held back while the output stalls.
// One item at a time: the next transaction is taken in the cycle after the result is
// loaded. A finished result waits in the output register.
// Reset clears the fill counts, window bases, sequencer and output valid, not the memory.
// ----------------------------------------------------------------------------
// Fingertip cell dwell detector
// Maps each point to a grid cell, votes the majority cell of the recent points
// and flags a touch when the nonzero voted cell matches the oldest entry of a full vote history.
// Memory contents are not cleared at reset and unwritten entries never reach the result.
// ----------------------------------------------------------------------------
module fingertip_cell_dwell_detector_unit
    import fcdd_pkg::*;
#(
    parameter int WINDOW_LENGTH = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // point_x [9:0], point_y [18:10], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // voted_cell [9:0], touch_x [19:10],
                                       // touch_y [28:20], zero pad
    output logic        m_axis_tuser   // touch [0]
);

    localparam int ADDR_W = $clog2(WINDOW_LENGTH);
    localparam int CNT_W  = $clog2(WINDOW_LENGTH + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(WINDOW_LENGTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_LOAD,
        S_SCAN,
        S_EVAL,
        S_VOTE,
        S_FINISH
    } t_state;

    // Map logical position (0 = oldest) to a physical memory address
    function automatic logic [ADDR_W-1:0] f_phys(input logic [ADDR_W-1:0] base,
                                                 input logic [CNT_W-1:0]  pos);
        logic [CNT_W:0] sum;
        begin
            sum = (CNT_W+1)'(base) + (CNT_W+1)'(pos);
            if (sum >= (CNT_W+1)'(WINDOW_LENGTH)) begin
                sum = sum - (CNT_W+1)'(WINDOW_LENGTH);
            end
            f_phys = sum[ADDR_W-1:0];
        end
    endfunction

    t_state              r_state;
    logic [CNT_W-1:0]    r_cell_fill;
    logic [ADDR_W-1:0]   r_cell_base;
    logic [CNT_W-1:0]    r_vote_fill;
    logic [ADDR_W-1:0]   r_vote_base;
    logic [CNT_W-1:0]    r_i;
    logic [CNT_W-1:0]    r_j;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    r_best_cnt;
    t_cell_entry         r_ref;
    t_cell_entry         r_best;
    logic                r_out_valid;
    logic [CODE_W-1:0]   r_voted;
    logic                r_touch;
    logic [X_W-1:0]      r_touch_x;
    logic [Y_W-1:0]      r_touch_y;

    t_cell_entry         cell_mem [WINDOW_LENGTH];
    t_cell_entry         vote_mem [WINDOW_LENGTH];
    t_cell_entry         r_cell_rdata;
    t_cell_entry         r_vote_rdata;

    t_cell_entry         in_entry;
    logic                in_accept;
    logic                out_free;
    logic [ADDR_W-1:0]   cell_wr_addr;
    logic [ADDR_W-1:0]   cell_rd_addr;
    logic [ADDR_W-1:0]   vote_wr_addr;
    logic [ADDR_W-1:0]   vote_rd_addr;
    logic [CNT_W-1:0]    n_i;
    logic [CNT_W-1:0]    n_best_cnt;
    logic                ref_hit;
    logic                touch_hit;

    fcdd_cell_map u_cell_map (
        .i_point_x (s_axis_tdata[X_W-1:0]),
        .i_point_y (s_axis_tdata[X_W+Y_W-1:X_W]),
        .o_entry   (in_entry)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // Push addresses: append while filling, overwrite the oldest once full
    assign cell_wr_addr = (r_cell_fill == FULL) ? r_cell_base : r_cell_fill[ADDR_W-1:0];
    assign vote_wr_addr = (r_vote_fill == FULL) ? r_vote_base : r_vote_fill[ADDR_W-1:0];

    // Oldest vote entry once the current vote is pushed
    assign vote_rd_addr = (r_vote_fill == FULL) ? f_phys(r_vote_base, CNT_W'(1)) : '0;

    // Window read address, presented ahead of the registered read data
    always_comb begin
        case (r_state)
            S_LOAD:  cell_rd_addr = f_phys(r_cell_base, r_i + CNT_W'(1));
            S_SCAN:  cell_rd_addr = f_phys(r_cell_base, r_j + CNT_W'(1));
            S_EVAL:  cell_rd_addr = f_phys(r_cell_base, r_i + CNT_W'(1));
            default: cell_rd_addr = f_phys(r_cell_base, r_i);
        endcase
    end

    assign ref_hit    = (r_cell_rdata.code == r_ref.code);
    assign n_i        = r_i + CNT_W'(1);
    assign n_best_cnt = (r_cnt > r_best_cnt) ? r_cnt : r_best_cnt;
    assign touch_hit  = (r_vote_fill == FULL) && (r_vote_rdata.code == r_best.code)
                        && (r_best.code != '0);

    // Window memory: write on accept, read every cycle
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            cell_mem[cell_wr_addr] <= in_entry;
        end
        r_cell_rdata <= cell_mem[cell_rd_addr];
    end

    // Vote history memory: push the vote and fetch the oldest in the same cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_VOTE) begin
            vote_mem[vote_wr_addr] <= r_best;
            r_vote_rdata           <= vote_mem[vote_rd_addr];
        end
    end

    // Sequencer, window bookkeeping and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cell_fill <= '0;
            r_cell_base <= '0;
            r_vote_fill <= '0;
            r_vote_base <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the taken result unless a new one is loaded this cycle
            if (r_out_valid && m_axis_tready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (r_cell_fill == FULL) begin
                            r_cell_base <= f_phys(r_cell_base, CNT_W'(1));
                        end else begin
                            r_cell_fill <= r_cell_fill + CNT_W'(1);
                        end
                        r_i        <= '0;
                        r_best_cnt <= CNT_W'(1);
                        r_best     <= '0;
                        r_state    <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    r_state <= S_LOAD;
                end
                // Take the reference entry and start counting its later repeats
                S_LOAD: begin
                    r_ref <= r_cell_rdata;
                    r_cnt <= CNT_W'(1);
                    r_j   <= n_i;
                    if (n_i < r_cell_fill) begin
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_EVAL;
                    end
                end
                S_SCAN: begin
                    if (ref_hit) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                    r_j <= r_j + CNT_W'(1);
                    if (r_j + CNT_W'(1) >= r_cell_fill) begin
                        r_state <= S_EVAL;
                    end
                end
                // Keep a strictly larger count; stop once no entry left can beat it
                S_EVAL: begin
                    if (r_cnt > r_best_cnt) begin
                        r_best_cnt <= r_cnt;
                        r_best     <= r_ref;
                    end
                    r_i <= n_i;
                    if ((n_i < r_cell_fill) && ((r_cell_fill - n_i) > n_best_cnt)) begin
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_VOTE;
                    end
                end
                S_VOTE: begin
                    if (r_vote_fill == FULL) begin
                        r_vote_base <= f_phys(r_vote_base, CNT_W'(1));
                    end else begin
                        r_vote_fill <= r_vote_fill + CNT_W'(1);
                    end
                    r_state <= S_FINISH;
                end
                // Hold until the output register is free, then load the result
                S_FINISH: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_voted     <= r_best.code;
                        r_touch     <= touch_hit;
                        r_touch_x   <= touch_hit ? X_W'({r_vote_rdata.col, HALF_CELL}) : '0;
                        r_touch_y   <= touch_hit ? Y_W'({r_vote_rdata.row, HALF_CELL}) : '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_touch_y, r_touch_x, r_voted};
    assign m_axis_tuser  = r_touch;

    // Fill counts never pass the window length
    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cell_fill <= FULL) && (r_vote_fill <= FULL))
        else $error("window fill count beyond window length");

    // The window base moves only once the window is full
    a_base_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cell_fill != FULL) |-> (r_cell_base == '0))
        else $error("cell window base moved before window full");

    // An accepted transaction grows a window that is not yet full
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (r_cell_fill != FULL)) |=> (r_cell_fill == $past(r_cell_fill) + CNT_W'(1)))
        else $error("cell fill did not advance on accepted transaction");

    // A touch needs a full vote history and a nonzero voted cell
    a_touch_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> ((r_vote_fill == FULL) && (r_voted != '0)))
        else $error("touch flagged without full history or with cell zero");

endmodule
